@@ design/vwlc_pkg.sv @@
// shared constants, types and character folding functions for the vowel and word length counter
package vwlc_pkg;

  localparam int MAX_WORD_LEN = 64;
  localparam int NUM_VOWELS   = 5;
  localparam int NUM_CTRS     = NUM_VOWELS + MAX_WORD_LEN;
  localparam int CTR_AW       = $clog2(NUM_CTRS);
  localparam int LEN_W        = $clog2(MAX_WORD_LEN + 1);
  localparam int CP_W         = 21;
  localparam int IDX_W        = 7;
  localparam int CNT_W        = 32;
  localparam int LW_W         = 7;
  localparam int LW_MAX       = (1 << LW_W) - 1;

  localparam logic [CP_W-1:0] CH_UP_A = CP_W'(8'h41);
  localparam logic [CP_W-1:0] CH_UP_Z = CP_W'(8'h5A);
  localparam logic [CP_W-1:0] CH_LO_A = CP_W'(8'h61);
  localparam logic [CP_W-1:0] CH_LO_Z = CP_W'(8'h7A);

  typedef enum logic [1:0] {
    REQ_CHAR  = 2'd0,
    REQ_FLUSH = 2'd1,
    REQ_READ  = 2'd2
  } req_e_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_INC,
    OP_READ
  } op_e_t;

  typedef struct packed {
    logic       is_letter;
    logic       is_vowel;
    logic [2:0] slot;
  } char_info_t;

  typedef struct packed {
    logic              bin_inc;
    logic [CTR_AW-1:0] bin_addr;
  } word_upd_t;

  function automatic logic [CP_W-1:0] fold_accent(input logic [CP_W-1:0] cp);
    logic [CP_W-1:0] c;
    c = cp;
    case (cp) inside
      21'h0E1, 21'h0E0, 21'h0E3, 21'h0E2:   c = CP_W'(8'h61);
      21'h0C1, 21'h0C0, 21'h0C3, 21'h0C2:   c = CP_W'(8'h41);
      21'h0E9, 21'h0E8, 21'h1EBD, 21'h0EA:  c = CP_W'(8'h65);
      21'h0C9, 21'h0C8, 21'h1EBC, 21'h0CA:  c = CP_W'(8'h45);
      21'h0ED, 21'h0EC, 21'h129, 21'h0EE:   c = CP_W'(8'h69);
      21'h0CD, 21'h0CC, 21'h128, 21'h0CE:   c = CP_W'(8'h49);
      21'h0F3, 21'h0F2, 21'h0F5, 21'h0F4:   c = CP_W'(8'h6F);
      21'h0D3, 21'h0D2, 21'h0D5, 21'h0D4:   c = CP_W'(8'h4F);
      21'h0FA, 21'h0F9, 21'h169, 21'h0FB:   c = CP_W'(8'h75);
      21'h0DA, 21'h0D9, 21'h168, 21'h0DB:   c = CP_W'(8'h55);
      default:                              c = cp;
    endcase
    return c;
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
  endfunction

endpackage

@@ design/vwlc_char_class.sv @@
// accent folding and letter / vowel classification of one code point
module vwlc_char_class
  import vwlc_pkg::*;
(
  input  logic [CP_W-1:0] code_point,
  output char_info_t      info
);

  logic [CP_W-1:0] c;

  always_comb begin
    c = fold_accent(code_point);
    info.is_letter = ((c >= CH_UP_A) && (c <= CH_UP_Z)) ||
                     ((c >= CH_LO_A) && (c <= CH_LO_Z));
    info.is_vowel = 1'b1;
    info.slot     = 3'd0;
    case (c) inside
      CP_W'(8'h61), CP_W'(8'h41): info.slot = 3'd0;
      CP_W'(8'h65), CP_W'(8'h45): info.slot = 3'd1;
      CP_W'(8'h69), CP_W'(8'h49): info.slot = 3'd2;
      CP_W'(8'h6F), CP_W'(8'h4F): info.slot = 3'd3;
      CP_W'(8'h75), CP_W'(8'h55): info.slot = 3'd4;
      default:                    info.is_vowel = 1'b0;
    endcase
  end

endmodule

@@ design/vwlc_word_track.sv @@
// running word length and longest word registers, histogram bin selection
module vwlc_word_track
  import vwlc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  req_e_t           req,
  input  logic             is_letter,
  output word_upd_t        upd,
  output logic [LEN_W-1:0] longest
);

  logic [LEN_W-1:0] cur_len;
  logic [LEN_W-1:0] cur_len_next;
  logic [LEN_W-1:0] longest_next;
  logic             grow;
  logic             finish;

  always_comb begin
    grow   = 1'b0;
    finish = 1'b0;
    case (req)
      REQ_CHAR: begin
        grow   = is_letter;
        finish = !is_letter;
      end
      REQ_FLUSH: finish = 1'b1;
      default: ;
    endcase
    upd.bin_inc  = finish && (cur_len != '0);
    upd.bin_addr = CTR_AW'(NUM_VOWELS) + CTR_AW'(cur_len) - CTR_AW'(1);
    cur_len_next = cur_len;
    longest_next = longest;
    if (grow && (cur_len < LEN_W'(MAX_WORD_LEN))) begin
      cur_len_next = cur_len + LEN_W'(1);
    end
    if (finish) begin
      cur_len_next = '0;
      if (cur_len > longest) begin
        longest_next = cur_len;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_len <= '0;
      longest <= '0;
    end else if (accept) begin
      cur_len <= cur_len_next;
      longest <= longest_next;
    end
  end

endmodule

@@ design/vwlc_ctr_ram.sv @@
// counter memory with per-entry valid bits, registered read
module vwlc_ctr_ram
  import vwlc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              rd_en,
  input  logic [CTR_AW-1:0] rd_addr,
  input  logic              wr_en,
  input  logic [CTR_AW-1:0] wr_addr,
  input  logic [CNT_W-1:0]  wr_data,
  output logic [CNT_W-1:0]  rd_data
);

  logic [CNT_W-1:0]  mem [0:NUM_CTRS-1];
  logic [NUM_CTRS-1:0] vld;
  logic [CNT_W-1:0]  rd_raw;
  logic              rd_vld;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_raw <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld <= vld[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld ? rd_raw : '0;

endmodule

@@ design/vowel_and_word_length_counter.sv @@
// vowel and word length counter top level: decode, counter read-modify-write and result word
// a read request's result word passes the counter ram read register and s1 into the m_tdata register
// throughput: one word per cycle while s_tready is high; at most one read-modify-write
//   per word of the single counter ram; a write to an entry the next word reads is forwarded
// s_tready drops only while a read result waits in s1 behind a stalled output register
// reset: rst clears counter valid bits, word length, longest word and pipeline valids
module vowel_and_word_length_counter
  import vwlc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,  // code_point[20:0], counter_index[27:21], zero pad
  input  logic [1:0]  s_tuser,  // req_type[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata   // count[31:0], longest_word[38:32], index_ok[39]
);

  logic              s_accept;
  logic              advance;
  req_e_t            req;
  logic [CP_W-1:0]   code_point;
  logic [IDX_W-1:0]  counter_index;
  char_info_t        info;
  word_upd_t         wupd;
  logic [LEN_W-1:0]  longest;

  op_e_t             s0_op;
  logic [CTR_AW-1:0] s0_addr;
  logic              s0_ok;

  logic              s1_valid;
  op_e_t             s1_op;
  logic [CTR_AW-1:0] s1_addr;
  logic              s1_ok;
  logic [LW_W-1:0]   s1_longest;
  logic              s1_fwd;
  logic [CNT_W-1:0]  s1_fwd_data;

  logic [CNT_W-1:0]  rd_data;
  logic [CNT_W-1:0]  cur_val;
  logic              wr_en;
  logic [CNT_W-1:0]  wr_data;

  assign req           = req_e_t'(s_tuser);
  assign code_point    = s_tdata[20:0];
  assign counter_index = s_tdata[27:21];

  assign advance  = !(s1_valid && (s1_op == OP_READ)) || !m_tvalid || m_tready;
  assign s_tready = advance;
  assign s_accept = s_tvalid && s_tready;

  vwlc_char_class u_class (
    .code_point (code_point),
    .info       (info)
  );

  vwlc_word_track u_word (
    .clk       (clk),
    .rst       (rst),
    .accept    (s_accept),
    .req       (req),
    .is_letter (info.is_letter),
    .upd       (wupd),
    .longest   (longest)
  );

  always_comb begin
    s0_op   = OP_NONE;
    s0_addr = '0;
    s0_ok   = 1'b0;
    case (req)
      REQ_CHAR: begin
        if (info.is_vowel) begin
          s0_op   = OP_INC;
          s0_addr = CTR_AW'(info.slot);
        end else if (wupd.bin_inc) begin
          s0_op   = OP_INC;
          s0_addr = wupd.bin_addr;
        end
      end
      REQ_FLUSH: begin
        if (wupd.bin_inc) begin
          s0_op   = OP_INC;
          s0_addr = wupd.bin_addr;
        end
      end
      REQ_READ: begin
        s0_op = OP_READ;
        if (counter_index < IDX_W'(NUM_CTRS)) begin
          s0_addr = CTR_AW'(counter_index);
          s0_ok   = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign cur_val = s1_fwd ? s1_fwd_data : rd_data;
  assign wr_en   = s1_valid && (s1_op == OP_INC);
  assign wr_data = sat_inc(cur_val);

  vwlc_ctr_ram u_ram (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (s_accept),
    .rd_addr (s0_addr),
    .wr_en   (wr_en),
    .wr_addr (s1_addr),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= s_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      s1_op       <= s0_op;
      s1_addr     <= s0_addr;
      s1_ok       <= s0_ok;
      s1_longest  <= (longest > LEN_W'(LW_MAX)) ? LW_W'(LW_MAX) : LW_W'(longest);
      s1_fwd      <= wr_en && (s1_addr == s0_addr);
      s1_fwd_data <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && s1_valid && (s1_op == OP_READ)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid && (s1_op == OP_READ)) begin
      m_tdata <= {s1_ok, s1_longest, s1_ok ? cur_val : {CNT_W{1'b0}}};
    end
  end

`ifndef SYNTH
  a_bad_index_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[39]) |-> (m_tdata[31:0] == '0))
    else $error("invalid index returned a non-zero count");

  a_longest_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[38:32] <= LW_W'(MAX_WORD_LEN)))
    else $error("longest word beyond maximum word length");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !advance) |=> (s1_valid && (s1_op == OP_READ) && $stable(s1_addr)))
    else $error("s1 read lost during output stall");

  a_no_write_on_read: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && (s1_op == OP_READ)) |-> !wr_en)
    else $error("counter written by a read request");
`endif

endmodule

@@ tb/vwlc_tally_checker.sv @@
`timescale 1ns / 1ps
// checker for the vowel and word length counter: predicts read replies and compares
module vwlc_tally_checker
  import vwlc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,  // code_point[20:0], counter_index[27:21], zero pad
  input  logic [1:0]  s_tuser,  // req_type[1:0]
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,  // count[31:0], longest_word[38:32], index_ok[39]
  output int          errors,
  output int          pending
);

  typedef struct {
    logic [CNT_W-1:0] count;
    logic [LW_W-1:0]  longest;
    logic             index_ok;
  } read_reply_t;

  read_reply_t      replies_due[$];
  logic [CNT_W-1:0] vowel_tally [NUM_VOWELS];
  logic [CNT_W-1:0] length_bins [MAX_WORD_LEN];
  int               word_run;
  int               longest_seen;
  int               fail_total = 0;

  function automatic logic [CP_W-1:0] to_plain(input logic [CP_W-1:0] cp);
    case (cp)
      21'h0E0, 21'h0E1, 21'h0E2, 21'h0E3:  return 21'h61;
      21'h0C0, 21'h0C1, 21'h0C2, 21'h0C3:  return 21'h41;
      21'h0E8, 21'h0E9, 21'h0EA, 21'h1EBD: return 21'h65;
      21'h0C8, 21'h0C9, 21'h0CA, 21'h1EBC: return 21'h45;
      21'h0EC, 21'h0ED, 21'h0EE, 21'h129:  return 21'h69;
      21'h0CC, 21'h0CD, 21'h0CE, 21'h128:  return 21'h49;
      21'h0F2, 21'h0F3, 21'h0F4, 21'h0F5:  return 21'h6F;
      21'h0D2, 21'h0D3, 21'h0D4, 21'h0D5:  return 21'h4F;
      21'h0F9, 21'h0FA, 21'h0FB, 21'h169:  return 21'h75;
      21'h0D9, 21'h0DA, 21'h0DB, 21'h168:  return 21'h55;
      default:                             return cp;
    endcase
  endfunction

  function automatic logic [CNT_W-1:0] bumped(input logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic void close_word();
    if (word_run != 0) begin
      length_bins[word_run-1] = bumped(length_bins[word_run-1]);
      if (word_run > longest_seen) longest_seen = word_run;
      word_run = 0;
    end
  endfunction

  function automatic void report(input string what, input logic [CNT_W-1:0] want,
                                 input logic [CNT_W-1:0] got);
    fail_total++;
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
  endfunction

  always @(posedge clk) begin
    read_reply_t      want;
    logic [CP_W-1:0]  ch;
    logic [CP_W-1:0]  lower;
    int               slot;
    int               idx;
    if (rst) begin
      replies_due.delete();
      foreach (vowel_tally[i]) vowel_tally[i] = '0;
      foreach (length_bins[i]) length_bins[i] = '0;
      word_run     = 0;
      longest_seen = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        case (s_tuser)
          REQ_CHAR: begin
            ch    = to_plain(s_tdata[CP_W-1:0]);
            lower = (ch >= CH_UP_A && ch <= CH_UP_Z) ? (ch | 21'h20) : ch;
            case (lower)
              21'h61:  slot = 0;
              21'h65:  slot = 1;
              21'h69:  slot = 2;
              21'h6F:  slot = 3;
              21'h75:  slot = 4;
              default: slot = -1;
            endcase
            if (slot >= 0) vowel_tally[slot] = bumped(vowel_tally[slot]);
            if ((ch >= CH_UP_A && ch <= CH_UP_Z) || (ch >= CH_LO_A && ch <= CH_LO_Z)) begin
              if (word_run < MAX_WORD_LEN) word_run++;
            end else begin
              close_word();
            end
          end
          REQ_FLUSH: close_word();
          REQ_READ: begin
            idx           = int'(s_tdata[CP_W +: IDX_W]);
            want.count    = '0;
            want.index_ok = 1'b0;
            if (idx < NUM_VOWELS) begin
              want.count    = vowel_tally[idx];
              want.index_ok = 1'b1;
            end else if (idx - NUM_VOWELS < MAX_WORD_LEN) begin
              want.count    = length_bins[idx-NUM_VOWELS];
              want.index_ok = 1'b1;
            end
            want.longest = (longest_seen > LW_MAX) ? LW_W'(LW_MAX) : LW_W'(longest_seen);
            replies_due.push_back(want);
          end
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        if (replies_due.size() == 0) begin
          fail_total++;
          $display("%0t: unexpected result word, expected none, got %h", $time, m_tdata);
        end else begin
          want = replies_due.pop_front();
          if (m_tdata[31:0] !== want.count) report("count", want.count, m_tdata[31:0]);
          if (m_tdata[38:32] !== want.longest)
            report("longest_word", CNT_W'(want.longest), CNT_W'(m_tdata[38:32]));
          if (m_tdata[39] !== want.index_ok)
            report("index_ok", CNT_W'(want.index_ok), CNT_W'(m_tdata[39]));
        end
      end
    end
    errors  <= fail_total;
    pending <= replies_due.size();
  end

endmodule

@@ tb/tb_vowel_and_word_length_counter.sv @@
`timescale 1ns / 1ps
// testbench top: clock, reset, text-like stimulus with random idling, output back-pressure and verdict
module tb_vowel_and_word_length_counter;
  import vwlc_pkg::*;

  localparam logic [1:0] REQ_UNUSED  = 2'd3;
  localparam int         RUN_ITEMS   = 1200;
  localparam int         HOLD_AT     = 500;
  localparam int         HOLD_CYCLES = 300;
  localparam int         CYCLE_LIMIT = 400000;

  localparam logic [CP_W-1:0] ACCENTED [40] = '{
    21'h0E1, 21'h0E0, 21'h0E3, 21'h0E2, 21'h0C1, 21'h0C0, 21'h0C3, 21'h0C2,
    21'h0E9, 21'h0E8, 21'h1EBD, 21'h0EA, 21'h0C9, 21'h0C8, 21'h1EBC, 21'h0CA,
    21'h0ED, 21'h0EC, 21'h129, 21'h0EE, 21'h0CD, 21'h0CC, 21'h128, 21'h0CE,
    21'h0F3, 21'h0F2, 21'h0F5, 21'h0F4, 21'h0D3, 21'h0D2, 21'h0D5, 21'h0D4,
    21'h0FA, 21'h0F9, 21'h169, 21'h0FB, 21'h0DA, 21'h0D9, 21'h168, 21'h0DB
  };

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;  // code_point[20:0], counter_index[27:21], zero pad
  logic [1:0]  s_tuser;  // req_type[1:0]
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;  // count[31:0], longest_word[38:32], index_ok[39]

  int   check_errors;
  int   replies_pending;
  int   items_sent = 0;
  int   tx_run     = 0;
  int   rx_run     = 0;
  int   cycles     = 0;
  logic rx_hold;

  vowel_and_word_length_counter uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  vwlc_tally_checker checker_i (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .errors   (check_errors),
    .pending  (replies_pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic int tx_gap();
    if (rx_hold) return 0;
    if (tx_run != 0) begin
      tx_run--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) begin
      tx_run = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 14);
  endfunction

  function automatic int rx_gap();
    if (rx_run != 0) begin
      rx_run--;
      return 0;
    end
    if ($urandom_range(0, 7) == 0) begin
      rx_run = $urandom_range(5, 25);
      return 0;
    end
    return $urandom_range(0, 14);
  endfunction

  task automatic offer(input logic [1:0] kind, input logic [CP_W-1:0] cp,
                       input logic [IDX_W-1:0] idx);
    int gap;
    gap = tx_gap();
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {4'd0, idx, cp};
    do @(posedge clk); while (!(s_tvalid && s_tready));
    items_sent++;
  endtask

  task automatic offer_char(input logic [CP_W-1:0] cp);
    offer(REQ_CHAR, cp, IDX_W'($urandom_range(0, 127)));
  endtask

  task automatic offer_read(input logic [IDX_W-1:0] idx);
    offer(REQ_READ, CP_W'($urandom_range(0, 21'h1FFFFF)), idx);
  endtask

  task automatic offer_flush();
    offer(REQ_FLUSH, CP_W'($urandom_range(0, 21'h1FFFFF)), IDX_W'($urandom_range(0, 127)));
  endtask

  task automatic send_word(input int len);
    logic [CP_W-1:0] cp;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 3) == 0)
        cp = ACCENTED[$urandom_range(0, 39)];
      else
        cp = ($urandom_range(0, 1) ? CH_UP_A : CH_LO_A) + CP_W'($urandom_range(0, 25));
      offer_char(cp);
    end
  endtask

  task automatic end_word();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 5)
      offer_char(CP_W'($urandom_range(8'h20, 8'h40)));
    else if (sel < 6)
      offer_flush();
    else if (sel < 8)
      offer_char($urandom_range(0, 1) ? CP_W'($urandom_range(8'h5B, 8'h60))
                                      : CP_W'($urandom_range(8'h7B, 8'h7F)));
    else if (sel < 9)
      offer_char(CP_W'($urandom_range(0, 21'h1FFFFF)));
  endtask

  // receiver: random stalls per word, held off entirely while rx_hold is set
  initial begin
    int gap;
    m_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      gap = rx_gap();
      if (gap != 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      while (rx_hold) begin
        m_tready <= 1'b0;
        @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
    end
  end

  // long output stall so the pipeline fills and the input backs up
  initial begin
    rx_hold <= 1'b0;
    wait (items_sent >= HOLD_AT);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  initial begin
    int pick;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= REQ_CHAR;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // counters straight after reset, top bin and an out-of-range index
    offer_read(7'd0);
    offer_read(7'd68);
    offer_read(7'd127);
    offer_flush();
    // letter range edges, their neighbours and accented letters
    offer_char(21'h41);
    offer_char(21'h5A);
    offer_char(21'h61);
    offer_char(21'h7A);
    offer_char(21'h40);
    offer_char(21'h0E1);
    offer_char(21'h1EBC);
    offer_char(21'h169);
    offer_char(21'h5B);
    offer_char(21'h60);
    offer_char(21'h0DB);
    offer_char(21'h7B);
    // code points past the unicode range, a vowel, an unused request type and reads, one out of range
    offer_char(21'h1FFFFF);
    offer_char(21'h110000);
    offer_char(21'h6F);
    offer(REQ_UNUSED, 21'h65, 7'd0);
    offer_flush();
    offer_read(7'd4);
    offer_read(7'd5);
    offer_read(7'd8);
    offer_read(7'd69);

    // a word past the top bin
    send_word(70);
    end_word();
    offer_read(7'd68);

    while (items_sent < RUN_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        send_word(($urandom_range(0, 24) == 0) ? $urandom_range(60, 70)
                                               : $urandom_range(1, 12));
        end_word();
      end else if (pick < 80) begin
        offer_read(($urandom_range(0, 7) == 0) ? IDX_W'($urandom_range(69, 127))
                                               : IDX_W'($urandom_range(0, 68)));
      end else if (pick < 90) begin
        offer_char(CP_W'($urandom_range(0, 21'h1FFFFF)));
      end else if (pick < 96) begin
        offer_flush();
      end else begin
        offer(REQ_UNUSED, CP_W'($urandom_range(0, 21'h1FFFFF)),
              IDX_W'($urandom_range(0, 127)));
      end
    end

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (replies_pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (check_errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

@@ vowel_and_word_length_counter.f @@
design/vwlc_pkg.sv
design/vwlc_char_class.sv
design/vwlc_word_track.sv
design/vwlc_ctr_ram.sv
design/vowel_and_word_length_counter.sv
tb/vwlc_tally_checker.sv
tb/tb_vowel_and_word_length_counter.sv
